// ===== rtl/otsc_pkg.sv =====
// types, constants and the crc update shared by the scratchpad check block
package otsc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned TempW    = 16;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned PosW     = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ByteW-1:0] CrcPoly = 8'h8C;

  localparam logic [TempW-1:0] RawReadError = 16'hFFFF;
  localparam logic [TempW-1:0] RawPowerOn   = 16'(85 * 16);

  localparam logic signed [TempW-1:0] LowLimitReset  = -16'sd880;
  localparam logic signed [TempW-1:0] HighLimitReset = 16'sd2000;

  localparam logic [PosW-1:0] PosFirst = 4'd0;
  localparam logic [PosW-1:0] PosHigh  = 4'd1;
  localparam logic [PosW-1:0] PosCrc   = 4'd8;
  localparam logic [PosW-1:0] PosIdle  = 4'd9;

  typedef enum logic [CfgIdxW-1:0] {
    RegLowLimit  = 2'd0,
    RegHighLimit = 2'd1
  } cfg_reg_e;

  typedef enum logic [StatusW-1:0] {
    StOk       = 3'd0,
    StCrcError = 3'd1,
    StReadErr  = 3'd2,
    StPowerOn  = 3'd3,
    StOutRange = 3'd4
  } status_e;

  typedef struct packed {
    logic signed [TempW-1:0] raw_temperature;
    logic [ByteW-1:0]        computed_crc;
    status_e                 status;
  } result_t;

  // reflected 1-wire crc, one byte at a time
  function automatic logic [ByteW-1:0] crc8_byte(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] data);
    logic [ByteW-1:0] c;
    c = crc ^ data;
    for (int b = 0; b < ByteW; b++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/otsc_if.sv =====
// valid/ready channel interfaces for scratchpad bytes, results and register writes
interface otsc_in_if;
  logic                          valid;
  logic                          ready;
  logic [otsc_pkg::ByteW-1:0]    byte_value;
  logic                          frame_start;

  modport source (output valid, byte_value, frame_start, input ready);
  modport sink   (input valid, byte_value, frame_start, output ready);
endinterface

interface otsc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [otsc_pkg::TempW-1:0] raw_temperature;
  logic [otsc_pkg::ByteW-1:0]        computed_crc;
  logic [otsc_pkg::StatusW-1:0]      status;

  modport source (output valid, raw_temperature, computed_crc, status, input ready);
  modport sink   (input valid, raw_temperature, computed_crc, status, output ready);
endinterface

interface otsc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [otsc_pkg::CfgIdxW-1:0]  reg_index;
  logic [otsc_pkg::CfgDataW-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== rtl/onewire_temp_scratchpad_check.sv =====
// top level of the 1-wire scratchpad check: input register, frame tracker, result register
//
//   channel  dir  beat carries                                 
//   in_i     in   byte_value[7:0], frame_start                 
//   out_o    out  raw_temperature[15:0], computed_crc, status  
//   cfg_i    in   reg_index[1:0], wdata[15:0] (low/high limit) 
//
// one byte per cycle unless a held result stalls byte 8; a beat waits in the
// input register, and its result shows on out_o the cycle after processing.
// reset clears the frame to position 0 and the limits to -880 and 2000.
// a held result only stalls a byte that would make the next result; other
// bytes keep flowing past it. register writes are always taken.
module onewire_temp_scratchpad_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  otsc_in_if.sink     in_i,
  otsc_out_if.source  out_o,
  otsc_cfg_if.sink    cfg_i
);

  logic                       in_vld_q;
  logic [otsc_pkg::ByteW-1:0] in_byte_q;
  logic                       in_start_q;

  logic signed [otsc_pkg::TempW-1:0] low_limit_q, high_limit_q;

  logic              out_vld_q;
  otsc_pkg::result_t out_res_q;

  logic              emit;
  logic              proc_fire;
  logic              load;
  logic              out_stall;
  otsc_pkg::result_t result;

  otsc_frame u_frame (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .beat_i        (proc_fire),
    .byte_value_i  (in_byte_q),
    .frame_start_i (in_start_q),
    .low_limit_i   (low_limit_q),
    .high_limit_i  (high_limit_q),
    .emit_o        (emit),
    .result_o      (result)
  );

  assign out_stall = out_vld_q && !out_o.ready;

  // emit only looks at the frame position, so it is valid before proc_fire is known
  assign proc_fire = in_vld_q && !(out_stall && emit);
  assign load      = proc_fire && emit;

  assign in_i.ready  = !in_vld_q || proc_fire;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid           = out_vld_q;
  assign out_o.raw_temperature = out_res_q.raw_temperature;
  assign out_o.computed_crc    = out_res_q.computed_crc;
  assign out_o.status          = out_res_q.status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q  <= in_i.byte_value;
      in_start_q <= in_i.frame_start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_limit_q  <= otsc_pkg::LowLimitReset;
      high_limit_q <= otsc_pkg::HighLimitReset;
    end else if (cfg_i.valid) begin
      if (cfg_i.reg_index == otsc_pkg::RegLowLimit) begin
        low_limit_q <= $signed(cfg_i.wdata);
      end
      if (cfg_i.reg_index == otsc_pkg::RegHighLimit) begin
        high_limit_q <= $signed(cfg_i.wdata);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_res_q <= result;
    end
  end

endmodule

// ===== rtl/otsc_frame.sv =====
// frame tracker: byte position, running crc, kept temperature bytes and status checks
module otsc_frame (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                beat_i,
  input  logic [otsc_pkg::ByteW-1:0]          byte_value_i,
  input  logic                                frame_start_i,
  input  logic signed [otsc_pkg::TempW-1:0]   low_limit_i,
  input  logic signed [otsc_pkg::TempW-1:0]   high_limit_i,
  output logic                                emit_o,
  output otsc_pkg::result_t                   result_o
);

  logic [otsc_pkg::PosW-1:0]  pos_q, pos_d, pos_eff;
  logic [otsc_pkg::ByteW-1:0] crc_q, crc_d, crc_eff;
  logic [otsc_pkg::ByteW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [otsc_pkg::TempW-1:0] raw_u;
  logic signed [otsc_pkg::TempW-1:0] raw_s;
  otsc_pkg::status_e status;

  // a start flag restarts the frame before this byte is looked at
  assign pos_eff = frame_start_i ? otsc_pkg::PosFirst : pos_q;
  assign crc_eff = frame_start_i ? '0 : crc_q;

  assign raw_u = {hi_q, lo_q};
  assign raw_s = $signed(raw_u);

  always_comb begin
    priority if (crc_eff != byte_value_i) begin
      status = otsc_pkg::StCrcError;
    end else if (raw_u == otsc_pkg::RawReadError) begin
      status = otsc_pkg::StReadErr;
    end else if (raw_u == otsc_pkg::RawPowerOn) begin
      status = otsc_pkg::StPowerOn;
    end else if (raw_s <= low_limit_i || raw_s >= high_limit_i) begin
      status = otsc_pkg::StOutRange;
    end else begin
      status = otsc_pkg::StOk;
    end
  end

  // the presented byte closes the frame; independent of beat_i
  assign emit_o   = (pos_eff == otsc_pkg::PosCrc);
  assign result_o = '{raw_temperature: raw_s, computed_crc: crc_eff, status: status};

  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    lo_d  = lo_q;
    hi_d  = hi_q;
    if (beat_i) begin
      pos_d = pos_eff;
      crc_d = crc_eff;
      if (pos_eff < otsc_pkg::PosCrc) begin
        crc_d = otsc_pkg::crc8_byte(crc_eff, byte_value_i);
        if (pos_eff == otsc_pkg::PosFirst) begin
          lo_d = byte_value_i;
        end
        if (pos_eff == otsc_pkg::PosHigh) begin
          hi_d = byte_value_i;
        end
        pos_d = pos_eff + 1'b1;
      end else if (pos_eff == otsc_pkg::PosCrc) begin
        pos_d = otsc_pkg::PosIdle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= '0;
      lo_q  <= '0;
      hi_q  <= '0;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
      lo_q  <= lo_d;
      hi_q  <= hi_d;
    end
  end

endmodule
